// ----- sv/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the PPS sync sample scheduler.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/psss_pkg.sv -----
// ============================================================================
// psss_pkg
// Shared types and constants of the PPS sync sample scheduler.
// ============================================================================
package psss_pkg;

   // Time constants in nanoseconds.
   localparam logic [29:0] HALF_SEC_NS     = 30'd500000000;
   localparam logic [30:0] NS_PER_SEC_S    = 31'd1000000000;
   localparam logic [45:0] NS_PER_SEC_WIDE = 46'd1000000000;
   localparam logic [29:0] NS_MAX          = 30'd999999999;

   // Control register indexes.
   localparam logic [2:0] CSR_SYNC_WINDOW  = 3'd0;
   localparam logic [2:0] CSR_SAMPLES_SEC  = 3'd1;
   localparam logic [2:0] CSR_PERIOD_NS    = 3'd2;
   localparam logic [2:0] CSR_ALARM_LEAD   = 3'd3;
   localparam logic [2:0] CSR_PPS_LEAD     = 3'd4;
   localparam logic [2:0] CSR_PPS_RUNNING  = 3'd5;

   // Event kinds carried on the request side.
   typedef enum logic {
      OP_STAMP   = 1'b0,
      OP_TRIGGER = 1'b1
   } opcode_type;

   // Control register set.
   typedef struct packed {
      logic [9:0]  sync_window_ns;
      logic [15:0] samples_per_second;
      logic [29:0] sample_period_ns;
      logic [3:0]  alarm_lead_seconds;
      logic [3:0]  pps_lead_seconds;
      logic        pps_running_at_start;
   } cfg_type;

   // Result item; the last member sits in the lowest bits.
   typedef struct packed {
      logic [15:0]        sample_count;
      logic [31:0]        pps_start_seconds;
      logic               pps_start;
      logic [29:0]        alarm_nanoseconds;
      logic [31:0]        alarm_seconds;
      logic               alarm_valid;
      logic               sync_changed;
      logic               is_synced;
      logic signed [29:0] time_error_ns;
   } rsp_type;

endpackage

// ----- sv/psss_csr.sv -----
// ============================================================================
// psss_csr
// Control register file with a single write channel.
// ============================================================================
module psss_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_addr,
   input  logic [29:0]        csr_wdata,
   output psss_pkg::cfg_type  cfg,
   output logic               pps_load
);
   import psss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    pps_load_ff;
   logic    pps_load_in;
   logic    write;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   // Register decode; unknown indexes are dropped.
   always_comb begin
      cfg_in      = cfg_ff;
      pps_load_in = 1'b0;
      if (write) begin
         case (csr_addr)
            CSR_SYNC_WINDOW: cfg_in.sync_window_ns     = csr_wdata[9:0];
            CSR_SAMPLES_SEC: cfg_in.samples_per_second = csr_wdata[15:0];
            CSR_PERIOD_NS:   cfg_in.sample_period_ns   = csr_wdata;
            CSR_ALARM_LEAD:  cfg_in.alarm_lead_seconds = csr_wdata[3:0];
            CSR_PPS_LEAD:    cfg_in.pps_lead_seconds   = csr_wdata[3:0];
            CSR_PPS_RUNNING: begin
               cfg_in.pps_running_at_start = csr_wdata[0];
               pps_load_in                 = 1'b1;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Register storage with reset defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_window_ns       <= 10'd100;
         cfg_ff.samples_per_second   <= 16'd4000;
         cfg_ff.sample_period_ns     <= 30'd250000;
         cfg_ff.alarm_lead_seconds   <= 4'd3;
         cfg_ff.pps_lead_seconds     <= 4'd2;
         cfg_ff.pps_running_at_start <= 1'b0;
         pps_load_ff                 <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         pps_load_ff <= pps_load_in;
      end
   end

   assign cfg      = cfg_ff;
   assign pps_load = pps_load_ff;

endmodule

// ----- sv/psss_event.sv -----
// ============================================================================
// psss_event
// Event evaluation and scheduler state for timestamp and trigger events.
// ============================================================================
module psss_event (
   input  logic                 clock,
   input  logic                 reset,
   input  psss_pkg::cfg_type    cfg,
   input  logic                 pps_load,
   input  logic                 fire,
   input  psss_pkg::opcode_type opcode,
   input  logic [31:0]          stamp_seconds,
   input  logic [29:0]          stamp_nanoseconds,
   output psss_pkg::rsp_type    result
);
   import psss_pkg::*;

   logic        synced_ff, synced_in;
   logic        pps_run_ff, pps_run_in;
   logic        first_set_ff, first_set_in;
   logic [15:0] index_ff, index_in;
   logic [31:0] alarm_sec_ff, alarm_sec_in;
   logic [29:0] alarm_ns_ff, alarm_ns_in;

   logic signed [30:0] err_full;
   logic signed [30:0] err_neg;
   logic [29:0]        err_mag;
   logic               now_synced;
   logic               first_clear;
   logic [16:0]        next_index;
   logic               roll;
   logic [45:0]        prod;

   // Wrapped time error and its magnitude.
   always_comb begin
      if (stamp_nanoseconds > HALF_SEC_NS) begin
         err_full = $signed({1'b0, stamp_nanoseconds}) - $signed(NS_PER_SEC_S);
      end else begin
         err_full = $signed({1'b0, stamp_nanoseconds});
      end
      err_neg    = -err_full;
      err_mag    = err_full[30] ? err_neg[29:0] : err_full[29:0];
      now_synced = err_mag < {20'd0, cfg.sync_window_ns};
   end

   // Next sample index and its alarm offset.
   assign next_index = {1'b0, index_ff} + 17'd1;
   assign roll       = next_index >= {1'b0, cfg.samples_per_second};
   assign prod       = next_index[15:0] * cfg.sample_period_ns;

   // Result and next state for the event at hand.
   always_comb begin
      synced_in    = synced_ff;
      pps_run_in   = pps_run_ff;
      first_set_in = first_set_ff;
      index_in     = index_ff;
      alarm_sec_in = alarm_sec_ff;
      alarm_ns_in  = alarm_ns_ff;
      first_clear  = first_set_ff;
      result       = '0;

      if (opcode == OP_STAMP) begin
         result.time_error_ns = err_full[29:0];
         if (now_synced != synced_ff) begin
            result.sync_changed = 1'b1;
            first_clear         = 1'b0;
         end
         synced_in    = now_synced;
         first_set_in = first_clear;
         // The first sample alarm is checked before the PPS start.
         if (pps_run_ff && !first_clear && now_synced) begin
            first_set_in             = 1'b1;
            alarm_sec_in             = stamp_seconds + {28'd0, cfg.alarm_lead_seconds};
            alarm_ns_in              = '0;
            result.alarm_valid       = 1'b1;
            result.alarm_seconds     = alarm_sec_in;
         end
         if (!pps_run_ff && now_synced) begin
            pps_run_in               = 1'b1;
            result.pps_start         = 1'b1;
            result.pps_start_seconds = stamp_seconds + {28'd0, cfg.pps_lead_seconds};
         end
         result.is_synced = now_synced;
      end else begin
         result.sample_count = index_ff;
         if (roll) begin
            index_in     = '0;
            alarm_sec_in = alarm_sec_ff + 32'd1;
            alarm_ns_in  = '0;
         end else begin
            index_in    = next_index[15:0];
            alarm_ns_in = (prod >= NS_PER_SEC_WIDE) ? NS_MAX : prod[29:0];
         end
         result.is_synced         = synced_ff;
         result.alarm_valid       = 1'b1;
         result.alarm_seconds     = alarm_sec_in;
         result.alarm_nanoseconds = alarm_ns_in;
      end
   end

   // State registers; a PPS-running register write reloads the running flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff    <= 1'b0;
         pps_run_ff   <= 1'b0;
         first_set_ff <= 1'b0;
         index_ff     <= '0;
         alarm_sec_ff <= '0;
         alarm_ns_ff  <= '0;
      end else if (pps_load) begin
         pps_run_ff <= cfg.pps_running_at_start;
      end else if (fire) begin
         synced_ff    <= synced_in;
         pps_run_ff   <= pps_run_in;
         first_set_ff <= first_set_in;
         index_ff     <= index_in;
         alarm_sec_ff <= alarm_sec_in;
         alarm_ns_ff  <= alarm_ns_in;
      end
   end

endmodule

// ----- sv/pps_sync_sample_scheduler.sv -----
// ============================================================================
// pps_sync_sample_scheduler
// PPS synchronization check and sample alarm scheduler, top level.
// ============================================================================
// Usage: events enter on the req_ stream, one per transfer. req_tuser selects
// an external PPS timestamp (0) or a target time trigger (1); req_tdata holds
// the timestamp. Each event yields exactly one result transfer on rsp_,
// carrying the time error, sync flags, any ordered alarm time, any PPS start
// order and, for triggers, the sample index sent.
// The input register loads at the request transfer edge; the result register
// loads from it when it is empty or its result is taken. rsp_tvalid is the
// result register's valid flag. Throughput is one event per cycle while
// rsp_tready stays high; the state update for an event is registered with its
// result, so the next event sees it at once.
// When rsp_tready is low the result register holds, the input register keeps
// one more event, and req_tready drops only when both are full.
// Reset clears all state and flags, empties both registers and restores the
// control register defaults. The csr_ channel writes a register each transfer;
// writing the PPS-running register also reloads the running flag. Write only
// while no event is in flight.
// ============================================================================
`include "assert_macros.svh"

module pps_sync_sample_scheduler (
   input  logic          clock,
   input  logic          reset,
   // Request stream.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // stamp_seconds[31:0], stamp_nanoseconds[61:32]
   input  logic          req_tuser,   // opcode[0]
   // Result stream.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,   // time_error_ns[29:0], is_synced[30],
                                      // sync_changed[31], alarm_valid[32],
                                      // alarm_seconds[64:33],
                                      // alarm_nanoseconds[94:65], pps_start[95],
                                      // pps_start_seconds[127:96],
                                      // sample_count[143:128]
   // Control register writes.
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_addr,
   input  logic [29:0]   csr_wdata
);
   import psss_pkg::*;

   cfg_type    cfg;
   logic       pps_load;
   rsp_type    result;

   logic       s1_vld_ff, s1_vld_in;
   opcode_type s1_op_ff;
   logic [31:0] s1_sec_ff;
   logic [29:0] s1_ns_ff;
   logic       out_vld_ff, out_vld_in;
   rsp_type    out_ff;
   logic       req_fire;
   logic       advance;

   psss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .pps_load  (pps_load)
   );

   psss_event u_event (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .pps_load          (pps_load),
      .fire              (advance),
      .opcode            (s1_op_ff),
      .stamp_seconds     (s1_sec_ff),
      .stamp_nanoseconds (s1_ns_ff),
      .result            (result)
   );

   // Handshake: the input register moves on when the result register frees up.
   assign advance    = s1_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_vld_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_vld_ff);
      out_vld_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= opcode_type'(req_tuser);
         s1_sec_ff <= req_tdata[31:0];
         s1_ns_ff  <= req_tdata[61:32];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   // Checks on the scheduling logic.
   `ASSERT_SAME_CYCLE(a_alarm_fields_zero, clock, reset,
      out_vld_ff && !out_ff.alarm_valid,
      out_ff.alarm_seconds == 32'd0 && out_ff.alarm_nanoseconds == 30'd0,
      "alarm time present without an alarm order")
   `ASSERT_SAME_CYCLE(a_start_needs_sync, clock, reset,
      out_vld_ff && out_ff.pps_start,
      out_ff.is_synced && !out_ff.alarm_valid,
      "PPS start ordered while unsynced or together with an alarm")
   `ASSERT_NEXT_CYCLE(a_accept_loads_stage, clock, reset,
      req_fire, s1_vld_ff,
      "accepted event did not reach the input register")
   `ASSERT_NEXT_CYCLE(a_trigger_orders_alarm, clock, reset,
      advance && s1_op_ff == OP_TRIGGER,
      out_vld_ff && out_ff.alarm_valid && out_ff.time_error_ns == 30'sd0,
      "trigger event did not order an alarm")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench for the PPS sync sample scheduler. Timestamp and
// trigger events go in on the request stream. Each accepted transfer is run
// through a scheduler predictor kept in the testbench. Every result transfer
// is checked field by field against the oldest predicted report. Directed
// events cover the error wrap, the sync window edges and the register
// extremes. Random events follow under several register settings and
// idle patterns, including a long result stall.
// ============================================================================
module tb_top;
   import psss_pkg::*;

   localparam int CLK_HALF_NS   = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 10;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 6;
   localparam int CHUNK_EVENTS  = 110;
   localparam int unsigned NS_PER_SEC = 1000000000;

   // Block ports; the inputs are at known values from time zero.
   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata  = '0;   // stamp_seconds[31:0], stamp_nanoseconds[61:32]
   logic          req_tuser  = 1'b0; // opcode[0]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [143:0]  rsp_tdata;         // time_error_ns[29:0], is_synced[30],
                                     // sync_changed[31], alarm_valid[32],
                                     // alarm_seconds[64:33],
                                     // alarm_nanoseconds[94:65], pps_start[95],
                                     // pps_start_seconds[127:96],
                                     // sample_count[143:128]
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [2:0]    csr_addr   = '0;
   logic [29:0]   csr_wdata  = '0;

   // Scheduler predictor: register copy and state.
   cfg_type       cfg;
   bit            synced          = 1'b0;
   bit            pps_running     = 1'b0;
   bit            first_alarm_set = 1'b0;
   logic [15:0]   sample_idx      = '0;
   logic [31:0]   alarm_sec       = '0;
   logic [29:0]   alarm_ns        = '0;

   // Reports predicted for accepted events, oldest first.
   rsp_type       sched_reports_q[$];

   int            failures      = 0;
   int            cycle_count   = 0;
   int            send_idle_pct = 20;
   int            recv_idle_pct = 20;
   bit            hold_request  = 1'b0;
   bit            hold_seen     = 1'b0;
   int            hold_left     = 0;

   pps_sync_sample_scheduler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Clock generation.
   always #(CLK_HALF_NS) clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Advance the predictor by one event and return the report it owes.
   function automatic rsp_type predict_schedule(opcode_type op, logic [31:0] sec,
                                                logic [29:0] ns);
      rsp_type          r;
      int               err;
      int               mag;
      bit               now_synced;
      int unsigned      nxt;
      longint unsigned  prod;
      r = '0;
      if (op == OP_STAMP) begin
         // Nanoseconds past half a second wrap to a negative error.
         err = int'({2'b00, ns});
         if (ns > HALF_SEC_NS) err = err - int'(NS_PER_SEC);
         mag = (err < 0) ? -err : err;
         now_synced = (mag < int'({22'd0, cfg.sync_window_ns}));
         if (now_synced != synced) begin
            r.sync_changed  = 1'b1;
            synced          = now_synced;
            first_alarm_set = 1'b0;
         end
         // The first alarm is looked at before the PPS start.
         if (pps_running && !first_alarm_set && synced) begin
            first_alarm_set = 1'b1;
            alarm_sec       = sec + 32'(cfg.alarm_lead_seconds);
            alarm_ns        = '0;
            r.alarm_valid   = 1'b1;
            r.alarm_seconds = alarm_sec;
         end
         if (!pps_running && synced) begin
            pps_running         = 1'b1;
            r.pps_start         = 1'b1;
            r.pps_start_seconds = sec + 32'(cfg.pps_lead_seconds);
         end
         r.time_error_ns = err[29:0];
      end else begin
         // Send the current index, then schedule the next alarm.
         r.sample_count = sample_idx;
         nxt = 32'(sample_idx) + 1;
         if (nxt >= 32'(cfg.samples_per_second)) begin
            sample_idx = '0;
            alarm_sec  = alarm_sec + 1;
            alarm_ns   = '0;
         end else begin
            prod = longint'(nxt) * longint'(cfg.sample_period_ns);
            if (prod >= NS_PER_SEC) prod = NS_PER_SEC - 1;
            sample_idx = nxt[15:0];
            alarm_ns   = prod[29:0];
         end
         r.alarm_valid       = 1'b1;
         r.alarm_seconds     = alarm_sec;
         r.alarm_nanoseconds = alarm_ns;
      end
      r.is_synced = synced;
      return r;
   endfunction

   task automatic note_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Result receiver: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checker: each transfer against the oldest predicted report.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      string   bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata);
         if (sched_reports_q.size() == 0) begin
            note_failure($sformatf("result with none pending: %h", rsp_tdata));
         end else begin
            want = sched_reports_q.pop_front();
            bad = "";
            if (got.time_error_ns !== want.time_error_ns)         bad = {bad, " time_error_ns"};
            if (got.is_synced !== want.is_synced)                 bad = {bad, " is_synced"};
            if (got.sync_changed !== want.sync_changed)           bad = {bad, " sync_changed"};
            if (got.alarm_valid !== want.alarm_valid)             bad = {bad, " alarm_valid"};
            if (got.alarm_seconds !== want.alarm_seconds)         bad = {bad, " alarm_seconds"};
            if (got.alarm_nanoseconds !== want.alarm_nanoseconds) bad = {bad, " alarm_nanoseconds"};
            if (got.pps_start !== want.pps_start)                 bad = {bad, " pps_start"};
            if (got.pps_start_seconds !== want.pps_start_seconds) bad = {bad, " pps_start_seconds"};
            if (got.sample_count !== want.sample_count)           bad = {bad, " sample_count"};
            if (bad != "")
               note_failure($sformatf("wrong%s: expected %h, got %h", bad, want, got));
         end
      end
   end

   // Offer one event until it is taken, then predict its report.
   task automatic send_event(opcode_type op, logic [31:0] sec, logic [29:0] ns);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, ns, sec};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sched_reports_q.push_back(predict_schedule(op, sec, ns));
      @(negedge clock);
   endtask

   task automatic send_trigger();
      send_event(OP_TRIGGER, $urandom, 30'($urandom));
   endtask

   // Stop offering and wait until every report is in and the block is quiet.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (sched_reports_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [29:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SYNC_WINDOW: cfg.sync_window_ns     = value[9:0];
         CSR_SAMPLES_SEC: cfg.samples_per_second = value[15:0];
         CSR_PERIOD_NS:   cfg.sample_period_ns   = value;
         CSR_ALARM_LEAD:  cfg.alarm_lead_seconds = value[3:0];
         CSR_PPS_LEAD:    cfg.pps_lead_seconds   = value[3:0];
         CSR_PPS_RUNNING: begin
            cfg.pps_running_at_start = value[0];
            pps_running              = value[0];
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Write the whole register set once the block has gone idle.
   task automatic load_settings(int unsigned window, int unsigned sps, int unsigned period,
                                int unsigned alarm_lead, int unsigned pps_lead,
                                int unsigned running);
      drain_reports();
      csr_write(CSR_SYNC_WINDOW, 30'(window));
      csr_write(CSR_SAMPLES_SEC, 30'(sps));
      csr_write(CSR_PERIOD_NS,   30'(period));
      csr_write(CSR_ALARM_LEAD,  30'(alarm_lead));
      csr_write(CSR_PPS_LEAD,    30'(pps_lead));
      csr_write(CSR_PPS_RUNNING, 30'(running));
   endtask

   // Default registers: error wrap, window edges and seconds wrap.
   task automatic test_default_settings();
      send_event(OP_STAMP, 32'd100, 30'd0);            // gains sync, starts PPS
      send_event(OP_STAMP, 32'd101, 30'd99);           // first alarm
      send_trigger();
      send_trigger();
      send_event(OP_STAMP, 32'd102, 30'd100);          // window edge, sync lost
      send_event(OP_STAMP, 32'd103, 30'd999999901);    // -99, sync again
      send_event(OP_STAMP, 32'd104, 30'd500000000);    // largest positive error
      send_event(OP_STAMP, 32'd105, 30'd500000001);    // first wrapped value
      send_event(OP_STAMP, 32'hFFFF_FFFF, 30'd999999999);
      send_event(OP_STAMP, 32'd0, 30'h3FFF_FFFF);      // above one second
      send_event(OP_STAMP, 32'hFFFF_FFFE, 30'd1000000000);
      send_trigger();
      drain_reports();
   endtask

   // Register extremes: zero window, zero rate, saturated period, top leads.
   task automatic test_setting_extremes();
      load_settings(0, 0, NS_PER_SEC, 15, 15, 0);
      send_event(OP_STAMP, 32'hFFFF_FFFF, 30'd0);      // zero window never syncs
      send_trigger();
      send_trigger();
      load_settings(1000, 65535, NS_PER_SEC, 15, 15, 1);
      send_event(OP_STAMP, 32'hFFFF_FFF0, 30'd999);    // alarm only, PPS running
      send_event(OP_STAMP, 32'hFFFF_FFF1, 30'd999999001);
      send_trigger();                                  // product saturates
      send_trigger();
      load_settings(1, 65535, 1, 0, 0, 0);
      send_event(OP_STAMP, 32'd7, 30'd0);              // PPS start, no alarm
      send_event(OP_STAMP, 32'd8, 30'd1);
      send_event(OP_STAMP, 32'd9, 30'd0);
      send_trigger();
      // Index left above a lowered rate rolls at once.
      load_settings(1000, 2, 250000, 3, 2, 1);
      send_trigger();
      send_trigger();
      drain_reports();
   endtask

   task automatic load_random_settings();
      int unsigned window;
      int unsigned sps;
      int unsigned period;
      window = ($urandom_range(19) == 0) ? 0 : $urandom_range(1000, 1);
      case ($urandom_range(9))
         0:       sps = 0;
         1, 2:    sps = $urandom_range(65535, 1);
         3:       sps = 65535;
         default: sps = $urandom_range(12, 1);
      endcase
      // Mostly periods that keep a second of alarms at most one and a quarter seconds.
      if (sps == 0 || $urandom_range(3) == 0) begin
         period = $urandom_range(NS_PER_SEC, 1);
      end else begin
         period = $urandom_range((NS_PER_SEC / sps / 4) * 5, 1);
         if (period > NS_PER_SEC) period = NS_PER_SEC;
      end
      load_settings(window, sps, period, $urandom_range(15), $urandom_range(15),
                    $urandom_range(1));
   endtask

   // Mostly stamps near the sync window and triggers; some wide noise.
   task automatic send_random_event();
      int unsigned pick;
      int unsigned off;
      logic [31:0] sec;
      logic [29:0] ns;
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) sec = 32'hFFFF_FFF0 + 32'($urandom_range(15));
      else sec = $urandom;
      off = $urandom_range(cfg.sync_window_ns + 2);
      case ($urandom_range(2))
         0:       ns = 30'(off);
         1:       ns = 30'(NS_PER_SEC - off);
         default: ns = 30'(NS_PER_SEC + off);
      endcase
      if (pick < 45)      send_trigger();
      else if (pick < 85) send_event(OP_STAMP, sec, ns);
      else if (pick < 95) send_event(OP_STAMP, sec, 30'($urandom));
      else                send_event(OP_STAMP, sec, 30'($urandom_range(NS_PER_SEC - 1)));
   endtask

   task automatic test_random_traffic(int events, int send_idle, int recv_idle);
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      for (int i = 0; i < events; i++) begin
         if (i % CHUNK_EVENTS == 0) load_random_settings();
         send_random_event();
      end
      drain_reports();
   endtask

   // Long result stall while events keep coming, so the input backs up.
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      hold_request  = ~hold_request;
      repeat (40) send_random_event();
      drain_reports();
   endtask

   initial begin
      cfg.sync_window_ns       = 10'd100;
      cfg.samples_per_second   = 16'd4000;
      cfg.sample_period_ns     = 30'd250000;
      cfg.alarm_lead_seconds   = 4'd3;
      cfg.pps_lead_seconds     = 4'd2;
      cfg.pps_running_at_start = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_settings();
      test_setting_extremes();
      test_random_traffic(550, 34, 81);
      test_result_backpressure();
      test_random_traffic(550, 81, 34);
      test_random_traffic(550, 0, 0);
      if (failures == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
